// ===== rtl/sfs_pkg.sv =====
// sfs_pkg: shared types and codes for the sprite frame sequencer.
// Word structs for both channels, configuration set, status flags.
// No dependencies.
package sfs_pkg;

    // Input word opcodes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    // Play status codes
    localparam logic [1:0] PS_PLAYING = 2'd0;
    localparam logic [1:0] PS_JUMP    = 2'd1;  // jump to start on next advance
    localparam logic [1:0] PS_FINAL   = 2'd2;  // final jump to end-at on next advance
    localparam logic [1:0] PS_STOPPED = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_FRAME_COUNT   = 3'd0;
    localparam logic [2:0] REG_BASE_INTERVAL = 3'd1;
    localparam logic [2:0] REG_REPEAT_DELAY  = 3'd2;
    localparam logic [2:0] REG_SWING_MODE    = 3'd3;
    localparam logic [2:0] REG_PLAY_START    = 3'd4;
    localparam logic [2:0] REG_PLAY_END      = 3'd5;
    localparam logic [2:0] REG_LOOP_TIMES    = 3'd6;
    localparam logic [2:0] REG_END_AT        = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ACC_W      = 32;

    localparam logic [8:0]       END_AT_IS_END = 9'd256;
    localparam logic [ACC_W-1:0] ACC_MAX       = '1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [23:0] tick_time;
        logic [7:0]  entry_index;
        logic [23:0] entry_delay;
    } in_word_t;

    typedef struct packed {
        logic [7:0] current_frame;
        logic       frame_changed;
        logic       completed;
        logic       stopped;
    } out_word_t;

    typedef struct packed {
        logic [8:0]  frame_count;
        logic [23:0] base_interval;
        logic [23:0] repeat_delay;
        logic        swing_mode;
        logic [7:0]  play_start;
        logic [7:0]  play_end;
        logic [15:0] loop_times;
        logic [8:0]  end_at;
    } cfg_t;

    typedef struct packed {
        logic       shown_none;
        logic       has_looped;
        logic       running_backward;
        logic [1:0] play_status;
    } flags_t;

endpackage

// ===== rtl/sprite_frame_sequencer.sv =====
// Sprite frame sequencer: frame timer with ping-pong and loop play control.
// A result word is registered in stage 1 and then in the output register after its input word is accepted.
// Loads and no-ops are taken at 1 word/cycle while result words are taken; a tick or restart
//   holds off the next word until it leaves stage 1, as that word's table read needs its state update.
// Reset: aresetn synchronous active low; clears config and play state, not the table.
// Depends on sfs_pkg, sfs_step and sfs_delay_ram.
module sprite_frame_sequencer #(
    parameter int MAX_FRAMES = 256,
    parameter int TIME_BITS  = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sfs_pkg::in_word_t                 s_data,
    // result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output sfs_pkg::out_word_t                m_data
);
    import sfs_pkg::*;

    // frame index width and stored delay width
    localparam int FW = $clog2(MAX_FRAMES);
    localparam int DW = (TIME_BITS < 24) ? TIME_BITS : 24;

    // ------------------------------------------------------------------
    // Pipeline:
    //   accept edge : delay table read at the (clamped) current frame,
    //                 tick time added into the saturating accumulator,
    //                 base (+ repeat at frame 0 after a loop) summed; loads write the table here.
    //   stage 1     : table entry added, compare/subtract, advance, play
    //                 rules, redraw check; state registers updated.
    //   output reg  : result word held until taken; stage 1 waits while it is not taken.
    // A tick or restart in stage 1 holds off the next word until it leaves stage 1,
    // because that word's table address depends on the frame it produces.
    // ------------------------------------------------------------------

    cfg_t cfg_reg;

    // play state
    logic [FW-1:0]    frame_index_reg;
    logic [FW-1:0]    shown_frame_reg;
    flags_t           flags_reg;
    logic [ACC_W-1:0] elapsed_reg;
    logic [15:0]      loops_left_reg;

    // stage 1
    logic             st1_valid_reg;
    logic [1:0]       st1_op_reg;
    logic [ACC_W-1:0] st1_acc_reg;
    logic [DW:0]      st1_dpart_reg;

    // output word
    logic             m_valid_reg;
    out_word_t        m_data_reg;

    logic             s_accept;
    logic             st1_fire;
    logic             st1_mod;
    logic             tbl_we;
    logic [DW-1:0]    tbl_rd_data;
    logic [FW-1:0]    rd_addr;
    logic [ACC_W-1:0] iss_acc;
    logic [DW:0]      iss_dpart;
    logic [FW-1:0]    frame_index_next;
    logic [FW-1:0]    shown_frame_next;
    flags_t           flags_next;
    logic [ACC_W-1:0] elapsed_next;
    logic [15:0]      loops_left_next;
    out_word_t        result;

    // handshakes
    assign st1_mod  = (st1_op_reg == OP_TICK) || (st1_op_reg == OP_RESTART);
    assign st1_fire = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !st1_valid_reg || (st1_fire && !st1_mod);
    assign s_accept = s_valid && s_ready;
    assign tbl_we   = s_accept && (s_data.opcode == OP_LOAD)
                   && (32'(s_data.entry_index) < MAX_FRAMES);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_count   <= 9'd1;
            cfg_reg.base_interval <= '0;
            cfg_reg.repeat_delay  <= '0;
            cfg_reg.swing_mode    <= 1'b0;
            cfg_reg.play_start    <= '0;
            cfg_reg.play_end      <= 8'd255;
            cfg_reg.loop_times    <= '0;
            cfg_reg.end_at        <= END_AT_IS_END;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FRAME_COUNT:   cfg_reg.frame_count   <= cfg_wdata[8:0];
                REG_BASE_INTERVAL: cfg_reg.base_interval <= cfg_wdata;
                REG_REPEAT_DELAY:  cfg_reg.repeat_delay  <= cfg_wdata;
                REG_SWING_MODE:    cfg_reg.swing_mode    <= cfg_wdata[0];
                REG_PLAY_START:    cfg_reg.play_start    <= cfg_wdata[7:0];
                REG_PLAY_END:      cfg_reg.play_end      <= cfg_wdata[7:0];
                REG_LOOP_TIMES:    cfg_reg.loop_times    <= cfg_wdata[15:0];
                REG_END_AT:        cfg_reg.end_at        <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    sfs_delay_ram #(
        .DEPTH (MAX_FRAMES),
        .AW    (FW),
        .DW    (DW)
    ) u_delay_ram (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (FW'(s_data.entry_index)),
        .wr_data (s_data.entry_delay[DW-1:0]),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (tbl_rd_data)
    );

    sfs_step #(
        .MAX_FRAMES (MAX_FRAMES),
        .FW         (FW),
        .DW         (DW)
    ) u_step (
        .cfg         (cfg_reg),
        .in_word     (s_data),
        .frame_index (frame_index_reg),
        .shown_frame (shown_frame_reg),
        .flags       (flags_reg),
        .elapsed     (elapsed_reg),
        .loops_left  (loops_left_reg),
        .st1_op      (st1_op_reg),
        .st1_acc     (st1_acc_reg),
        .st1_dpart   (st1_dpart_reg),
        .rd_data     (tbl_rd_data),
        .rd_addr     (rd_addr),
        .iss_acc     (iss_acc),
        .iss_dpart   (iss_dpart),
        .n_frame     (frame_index_next),
        .n_shown     (shown_frame_next),
        .n_flags     (flags_next),
        .n_elapsed   (elapsed_next),
        .n_loops     (loops_left_next),
        .result      (result)
    );

    // stage 1 capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_fire) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_op_reg    <= s_data.opcode;
            st1_acc_reg   <= iss_acc;
            st1_dpart_reg <= iss_dpart;
        end
    end

    // play state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_index_reg <= '0;
            shown_frame_reg <= '0;
            flags_reg       <= '{shown_none: 1'b1, has_looped: 1'b0,
                                 running_backward: 1'b0, play_status: PS_PLAYING};
            elapsed_reg     <= '0;
            loops_left_reg  <= '0;
        end else if (st1_fire) begin
            frame_index_reg <= frame_index_next;
            shown_frame_reg <= shown_frame_next;
            flags_reg       <= flags_next;
            elapsed_reg     <= elapsed_next;
            loops_left_reg  <= loops_left_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_fire) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // completion only ever comes with the stop
    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.completed) |-> m_data_reg.stopped)
        else $error("completed word without stopped");

    // a stopped sequencer ignores ticks
    a_stop_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_fire && (st1_op_reg == OP_TICK) && (flags_reg.play_status == PS_STOPPED))
        |=> ($stable(frame_index_reg) && $stable(elapsed_reg)))
        else $error("tick changed state while stopped");

    // restart with a nonzero frame count clears the accumulator
    a_restart_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_fire && (st1_op_reg == OP_RESTART) && (cfg_reg.frame_count != '0))
        |=> (elapsed_reg == '0) && (flags_reg.play_status == PS_PLAYING))
        else $error("restart did not reset play state");

endmodule

// ===== rtl/sfs_delay_ram.sv =====
// sfs_delay_ram: per-frame extra delay table, one write and one read port.
// Synchronous read with a registered output. No package dependency.
module sfs_delay_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 24
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sfs_step.sv =====
// sfs_step: next-state logic of the sequencer.
// Issue side: table address, accumulated time, partial delay.
// Finish side: time compare, frame advance, play rules, redraw. Uses sfs_pkg.
module sfs_step #(
    parameter int MAX_FRAMES = 256,
    parameter int FW         = 8,
    parameter int DW         = 24
) (
    input  sfs_pkg::cfg_t                 cfg,
    input  sfs_pkg::in_word_t             in_word,
    input  logic [FW-1:0]                 frame_index,
    input  logic [FW-1:0]                 shown_frame,
    input  sfs_pkg::flags_t               flags,
    input  logic [sfs_pkg::ACC_W-1:0]     elapsed,
    input  logic [15:0]                   loops_left,
    input  logic [1:0]                    st1_op,
    input  logic [sfs_pkg::ACC_W-1:0]     st1_acc,
    input  logic [DW:0]                   st1_dpart,
    input  logic [DW-1:0]                 rd_data,
    output logic [FW-1:0]                 rd_addr,
    output logic [sfs_pkg::ACC_W-1:0]     iss_acc,
    output logic [DW:0]                   iss_dpart,
    output logic [FW-1:0]                 n_frame,
    output logic [FW-1:0]                 n_shown,
    output sfs_pkg::flags_t               n_flags,
    output logic [sfs_pkg::ACC_W-1:0]     n_elapsed,
    output logic [15:0]                   n_loops,
    output sfs_pkg::out_word_t            result
);
    import sfs_pkg::*;

    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int XW = (CW > 9) ? CW : 9;

    logic [CW-1:0]    fc;
    logic [XW-1:0]    cnt_x;
    logic [FW-1:0]    f_cur;
    logic [FW-1:0]    start_c;
    logic [FW-1:0]    end_c;
    logic [FW-1:0]    endat_c;
    logic [DW-1:0]    base_t;
    logic [DW-1:0]    rep_t;
    logic [ACC_W:0]   acc_sum;
    logic [CW-1:0]    fwd;
    logic             at_top;
    logic [FW-1:0]    adv_frame;
    logic             adv_looped;
    logic             adv_back;
    logic [ACC_W-1:0] delay_x;
    logic [ACC_W-1:0] rem;
    logic             changed;
    logic             done;

    function automatic logic [FW-1:0] clampf(input logic [XW-1:0] f, input logic [CW-1:0] c);
        logic [XW-1:0] lim;
        lim = XW'(c) - XW'(1);
        return (f > lim) ? FW'(lim) : FW'(f);
    endfunction

    // effective frame count, saturated at the table depth
    assign cnt_x   = XW'(cfg.frame_count);
    assign fc      = (cnt_x > XW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(cnt_x);
    assign f_cur   = clampf(XW'(frame_index), fc);
    assign start_c = clampf(XW'(cfg.play_start), fc);
    assign end_c   = clampf(XW'(cfg.play_end), fc);
    assign endat_c = (cfg.end_at == END_AT_IS_END) ? end_c : clampf(XW'(cfg.end_at), fc);
    assign base_t  = cfg.base_interval[DW-1:0];
    assign rep_t   = cfg.repeat_delay[DW-1:0];

    // issue side
    assign rd_addr   = f_cur;
    assign acc_sum   = {1'b0, elapsed} + (ACC_W+1)'(in_word.tick_time[DW-1:0]);
    assign iss_acc   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
    assign iss_dpart = (DW+1)'(base_t)
                     + (((f_cur == '0) && flags.has_looped) ? (DW+1)'(rep_t) : '0);

    // single frame advance
    assign fwd    = CW'(f_cur) + CW'(1);
    assign at_top = (fwd >= fc);

    always_comb begin
        adv_frame  = FW'(fwd);
        adv_looped = 1'b0;
        adv_back   = flags.running_backward;
        if (cfg.swing_mode) begin
            if (flags.running_backward) begin
                if (f_cur <= FW'(1)) begin
                    adv_frame  = '0;
                    adv_looped = 1'b1;
                    adv_back   = 1'b0;
                end else begin
                    adv_frame = f_cur - FW'(1);
                end
            end else if (at_top) begin
                adv_frame  = (fc >= CW'(2)) ? FW'(fc - CW'(2)) : '0;
                adv_looped = 1'b1;
                adv_back   = 1'b1;
            end
        end else if (at_top) begin
            adv_frame  = '0;
            adv_looped = 1'b1;
        end
    end

    // finish side
    assign delay_x = ACC_W'(st1_dpart) + ACC_W'(rd_data);
    assign rem     = st1_acc - delay_x;

    always_comb begin
        n_frame   = frame_index;
        n_shown   = shown_frame;
        n_flags   = flags;
        n_elapsed = elapsed;
        n_loops   = loops_left;
        changed   = 1'b0;
        done      = 1'b0;
        unique case (st1_op)
            OP_TICK: begin
                if ((fc != '0) && (flags.play_status != PS_STOPPED)) begin
                    n_frame   = f_cur;
                    n_elapsed = st1_acc;
                    if (st1_acc >= delay_x) begin
                        n_elapsed = (rem > ACC_W'(base_t)) ? ACC_W'(base_t) : rem;
                        n_frame   = adv_frame;
                        n_flags.has_looped       = flags.has_looped | adv_looped;
                        n_flags.running_backward = adv_back;
                        case (flags.play_status)
                            PS_JUMP: begin
                                n_frame             = start_c;
                                n_elapsed           = '0;
                                n_flags.play_status = PS_PLAYING;
                            end
                            PS_FINAL: begin
                                n_frame             = endat_c;
                                n_elapsed           = '0;
                                n_flags.play_status = PS_STOPPED;
                                done                = 1'b1;
                            end
                            PS_PLAYING: begin
                                if (adv_frame == end_c) begin
                                    if (loops_left != '0) begin
                                        n_loops = loops_left - 16'd1;
                                        n_flags.play_status =
                                            (loops_left == 16'd1) ? PS_FINAL : PS_JUMP;
                                    end else if (cfg.play_start != '0) begin
                                        n_flags.play_status = PS_JUMP;
                                    end
                                end
                            end
                            PS_STOPPED: ;
                            default: ;
                        endcase
                        changed            = flags.shown_none || (shown_frame != n_frame);
                        n_shown            = n_frame;
                        n_flags.shown_none = 1'b0;
                    end
                end
            end
            OP_RESTART: begin
                if (fc != '0) begin
                    n_loops             = cfg.loop_times;
                    n_flags.play_status = PS_PLAYING;
                    n_frame             = start_c;
                    n_elapsed           = '0;
                    n_shown             = start_c;
                    n_flags.shown_none  = 1'b0;
                    changed             = 1'b1;
                end
            end
            OP_LOAD: ;
            OP_NOP: ;
            default: ;
        endcase
    end

    assign result.current_frame = 8'(n_frame);
    assign result.frame_changed = changed;
    assign result.completed     = done;
    assign result.stopped       = (n_flags.play_status == PS_STOPPED);

endmodule
